// ===== rtl/core/multi_servo_pulse_generator_assert.svh =====
// Assertion macros used by the servo pulse generator checker.
`ifndef MULTI_SERVO_PULSE_GENERATOR_ASSERT_SVH
`define MULTI_SERVO_PULSE_GENERATOR_ASSERT_SVH

// Clocked check, quiet while reset is held.
`define MSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define MSP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/msp_pkg.sv =====
// Shared constants, register indexes and reset tables for the servo pulse generator.
package msp_pkg;

    localparam int CHANNELS_DEF        = 12;
    localparam int SLOTS_PER_FRAME_DEF = 20;
    localparam int TICKS_PER_SLOT_DEF  = 250;

    localparam int POS_W      = 8;   // position / target width
    localparam int TICK_W     = 8;   // tick counter width
    localparam int RCNT_W     = 8;   // ramp slot counter width
    localparam int CH_FIELD_W = 4;   // channel field width
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RAMP_STEP  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RAMP_DELAY = 1'd1;

    localparam logic [CFG_DATA_W-1:0] RAMP_STEP_RST  = 8'd1;
    localparam logic [CFG_DATA_W-1:0] RAMP_DELAY_RST = 8'd10;

    // Request codes
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_TARGET = 1'b1;

    // Power-up position pattern, repeats every six channels.
    function automatic logic [POS_W-1:0] start_pos(input int unsigned k);
        logic [POS_W-1:0] v;
        case (k % 6)
            0, 1:    v = 8'd225;
            2, 3:    v = 8'd125;
            default: v = 8'd25;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/msp_ramp.sv =====
// Per-channel slew step: moves each position one ramp step toward its target.
module msp_ramp #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEF
) (
    input  logic [CHANNELS-1:0][msp_pkg::POS_W-1:0] i_pos,
    input  logic [CHANNELS-1:0][msp_pkg::POS_W-1:0] i_tgt,
    input  logic [msp_pkg::POS_W-1:0]               i_step,
    output logic [CHANNELS-1:0][msp_pkg::POS_W-1:0] o_pos,
    output logic                                    o_differs
);
    import msp_pkg::*;

    logic [POS_W:0] w_up   [CHANNELS];
    logic [POS_W:0] w_tlim [CHANNELS];

    always_comb begin
        o_differs = 1'b0;
        for (int k = 0; k < CHANNELS; k++) begin
            w_up[k]   = {1'b0, i_pos[k]} + {1'b0, i_step};
            w_tlim[k] = {1'b0, i_tgt[k]} + {1'b0, i_step};
            o_pos[k]  = i_pos[k];
            if (i_pos[k] < i_tgt[k]) begin
                o_pos[k] = (w_up[k] > {1'b0, i_tgt[k]}) ? i_tgt[k] : w_up[k][POS_W-1:0];
            end else if (i_pos[k] > i_tgt[k]) begin
                // clamp: overshoot below target lands on target
                o_pos[k] = ({1'b0, i_pos[k]} < w_tlim[k]) ? i_tgt[k] : i_pos[k] - i_step;
            end
            if (i_pos[k] != i_tgt[k]) begin
                o_differs = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/msp_out_buf.sv =====
// Two-entry output buffer: result register plus skid stage.
module msp_out_buf #(
    parameter int W = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_stall
);
    logic         r_main_valid, n_main_valid;
    logic         r_skid_valid, n_skid_valid;
    logic [W-1:0] r_main, n_main;
    logic [W-1:0] r_skid, n_skid;
    logic         w_pop;

    assign w_pop   = r_main_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (w_pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_main = i_data;
            end else begin
                n_main_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

// ===== rtl/core/multi_servo_pulse_generator.sv =====
// Top level of the multichannel servo pulse generator.
// Usage:
//   Input channel (i_valid / o_stall): each item is either one 4 us time
//   tick (i_req_type = tick) or a target write for i_channel. Writes to a
//   channel number at or above CHANNELS are dropped.
//   Output channel (o_valid / i_stall): exactly one result per item: the
//   servo pin levels, ramp_busy and frame_start after that item.
//   Config port: i_cfg_we, i_cfg_addr 0 = ramp_step, 1 = ramp_delay_ms; idle only.
// Timing:
//   Every item is worked in the cycle it is accepted; the state and the
//   result register, or the skid stage while a result waits, load at that same edge.
//   Throughput is one item per cycle while o_stall is low, set by the single
//   combinational pass through the ramp lanes and slot counters.
// Stall:
//   The result register is backed by a one-entry skid stage, so one more
//   item is taken while a result waits; o_stall rises only when both are
//   full and drops as soon as the receiver drains one.
// Reset:
//   Synchronous, active low. Positions and targets load the power-up
//   pattern, counters and pins clear, ramp_step = 1, ramp_delay_ms = 10.
module multi_servo_pulse_generator #(
    parameter int CHANNELS        = msp_pkg::CHANNELS_DEF,
    parameter int SLOTS_PER_FRAME = msp_pkg::SLOTS_PER_FRAME_DEF,
    parameter int TICKS_PER_SLOT  = msp_pkg::TICKS_PER_SLOT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_req_type,
    input  logic [msp_pkg::CH_FIELD_W-1:0]    i_channel,
    input  logic [msp_pkg::POS_W-1:0]         i_target,
    // result items
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [CHANNELS-1:0]               o_servo_pins,
    output logic                              o_ramp_busy,
    output logic                              o_frame_start,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [msp_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [msp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import msp_pkg::*;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W = $clog2(SLOTS_PER_FRAME);
    localparam int OUT_W  = CHANNELS + 2;

    // config
    logic [POS_W-1:0]  r_ramp_step;
    logic [RCNT_W-1:0] r_ramp_delay;

    // block state
    logic [CHANNELS-1:0][POS_W-1:0] r_pos, n_pos;
    logic [CHANNELS-1:0][POS_W-1:0] r_tgt, n_tgt;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [TICK_W-1:0]  r_tick, n_tick;
    logic [POS_W-1:0]   r_cd, n_cd;
    logic               r_pend, n_pend;
    logic [CH_W-1:0]    r_offch, n_offch;
    logic [RCNT_W-1:0]  r_rcnt, n_rcnt;
    logic [CHANNELS-1:0] r_pins, n_pins;

    logic                           w_accept;
    logic                           w_full;
    logic [CHANNELS-1:0][POS_W-1:0] w_ramp_pos;
    logic                           w_differs;
    logic                           w_slot_begin;
    logic [5:0]                     w_slot_m1;
    logic                           w_fstart;
    logic                           w_busy;
    logic [OUT_W-1:0]               w_out_data;
    logic [OUT_W-1:0]               w_buf_data;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    msp_ramp #(
        .CHANNELS (CHANNELS)
    ) u_ramp (
        .i_pos     (r_pos),
        .i_tgt     (r_tgt),
        .i_step    (r_ramp_step),
        .o_pos     (w_ramp_pos),
        .o_differs (w_differs)
    );

    assign w_slot_begin = (r_tick == '0);
    assign w_slot_m1    = 6'(r_slot) - 6'd1;

    always_comb begin
        n_pos    = r_pos;
        n_tgt    = r_tgt;
        n_slot   = r_slot;
        n_tick   = r_tick;
        n_cd     = r_cd;
        n_pend   = r_pend;
        n_offch  = r_offch;
        n_rcnt   = r_rcnt;
        n_pins   = r_pins;
        w_fstart = 1'b0;
        if (w_accept) begin
            if (i_req_type == REQ_TARGET) begin
                if ({1'b0, i_channel} < 5'(CHANNELS)) begin
                    n_tgt[i_channel[CH_W-1:0]] = i_target;
                end
            end else begin
                // ramp: slot countdown, then a move when due
                if (w_slot_begin && r_rcnt != '0) begin
                    n_rcnt = r_rcnt - 1'b1;
                end
                if (w_differs) begin
                    if (r_ramp_delay == '0 || n_rcnt == '0) begin
                        n_pos  = w_ramp_pos;
                        n_rcnt = r_ramp_delay;
                    end
                end else begin
                    n_rcnt = '0;
                end

                // slot start: raise this slot's pin, arm the previous one's tail
                if (w_slot_begin) begin
                    w_fstart = (r_slot == '0);
                    for (int k = 0; k < CHANNELS; k++) begin
                        if (6'(r_slot) == 6'(k)) begin
                            n_pins[k] = 1'b1;
                        end
                    end
                    if (r_slot != '0 && 6'(r_slot) <= 6'(CHANNELS)) begin
                        // a tail still running past a whole slot is cut here
                        if (r_pend) begin
                            for (int k = 0; k < CHANNELS; k++) begin
                                if (r_offch == CH_W'(k)) begin
                                    n_pins[k] = 1'b0;
                                end
                            end
                        end
                        n_offch = w_slot_m1[CH_W-1:0];
                        n_cd    = n_pos[w_slot_m1[CH_W-1:0]];
                        n_pend  = 1'b1;
                    end
                end

                // tail countdown; zero position drops the pin right away
                if (n_pend) begin
                    if (n_cd == '0) begin
                        for (int k = 0; k < CHANNELS; k++) begin
                            if (n_offch == CH_W'(k)) begin
                                n_pins[k] = 1'b0;
                            end
                        end
                        n_pend = 1'b0;
                    end else begin
                        n_cd = n_cd - 1'b1;
                    end
                end

                // time base
                if (r_tick == TICK_W'(TICKS_PER_SLOT - 1)) begin
                    n_tick = '0;
                    if (r_slot == SLOT_W'(SLOTS_PER_FRAME - 1)) begin
                        n_slot = '0;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_busy = 1'b0;
        for (int k = 0; k < CHANNELS; k++) begin
            if (n_pos[k] != n_tgt[k]) begin
                w_busy = 1'b1;
            end
        end
    end

    assign w_out_data = {n_pins, w_busy, w_fstart};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step  <= RAMP_STEP_RST;
            r_ramp_delay <= RAMP_DELAY_RST;
            for (int k = 0; k < CHANNELS; k++) begin
                r_pos[k] <= start_pos(k);
                r_tgt[k] <= start_pos(k);
            end
            r_slot  <= '0;
            r_tick  <= '0;
            r_cd    <= '0;
            r_pend  <= 1'b0;
            r_offch <= '0;
            r_rcnt  <= '0;
            r_pins  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_RAMP_STEP:  r_ramp_step  <= i_cfg_wdata;
                    REG_RAMP_DELAY: r_ramp_delay <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_pos   <= n_pos;
            r_tgt   <= n_tgt;
            r_slot  <= n_slot;
            r_tick  <= n_tick;
            r_cd    <= n_cd;
            r_pend  <= n_pend;
            r_offch <= n_offch;
            r_rcnt  <= n_rcnt;
            r_pins  <= n_pins;
        end
    end

    msp_out_buf #(
        .W (OUT_W)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_out_data),
        .o_full  (w_full),
        .o_valid (o_valid),
        .o_data  (w_buf_data),
        .i_stall (i_stall)
    );

    assign o_servo_pins  = w_buf_data[OUT_W-1:2];
    assign o_ramp_busy   = w_buf_data[1];
    assign o_frame_start = w_buf_data[0];

endmodule

// ===== rtl/core/msp_checker.sv =====
// Port-level checks for the servo pulse generator, bound to the top level.
`include "multi_servo_pulse_generator_assert.svh"

module msp_checker #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [CHANNELS-1:0] o_servo_pins,
    input logic                o_ramp_busy,
    input logic                o_frame_start
);
    import msp_pkg::*;

    // a held result keeps its payload
    `MSP_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_servo_pins) && $stable(o_ramp_busy) && $stable(o_frame_start), "result changed while stalled")

    // reset empties the output side
    `MSP_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_valid && !o_stall, "output not empty after reset")

    // the skid stage fills only from an item taken against a stalled result
    `MSP_ASSERT(a_stall_cause, $rose(o_stall) |-> $past(i_valid && o_valid && i_stall), "stall raised without a stalled result")

    // a frame start always raises channel zero
    `MSP_ASSERT(a_frame_pin0, o_valid && o_frame_start |-> o_servo_pins[0], "frame start without channel zero high")

endmodule

bind multi_servo_pulse_generator msp_checker #(.CHANNELS(CHANNELS)) u_msp_checker (.*);

// ===== verif/multi_servo_pulse_generator_tb.sv =====
// Self-checking testbench for the twelve-channel servo pulse generator.
module multi_servo_pulse_generator_tb;
    import msp_pkg::*;

    localparam int NCH        = CHANNELS_DEF;
    localparam int NSLOT      = SLOTS_PER_FRAME_DEF;
    localparam int NTICK      = TICKS_PER_SLOT_DEF;
    localparam int QUIET_MAX  = 1000;  // cycles with no handshake before giving up
    localparam int LONG_HOLD  = 120;   // receiver back-pressure stretch
    // power-up positions, channel 0 in the low byte, pattern repeats every six
    localparam logic [6*POS_W-1:0] HOME_POS =
        {8'd25, 8'd25, 8'd125, 8'd125, 8'd225, 8'd225};

    typedef struct packed {
        logic                  req;
        logic [CH_FIELD_W-1:0] ch;
        logic [POS_W-1:0]      tg;
    } servo_cmd_t;

    typedef struct packed {
        logic [NCH-1:0] pins;
        logic           busy;
        logic           fstart;
    } servo_out_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  i_req_type  = REQ_TICK;
    logic [CH_FIELD_W-1:0] i_channel   = '0;
    logic [POS_W-1:0]      i_target    = '0;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = REG_RAMP_STEP;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic [NCH-1:0]        o_servo_pins;
    logic                  o_ramp_busy;
    logic                  o_frame_start;

    multi_servo_pulse_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_channel     (i_channel),
        .i_target      (i_target),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_servo_pins  (o_servo_pins),
        .o_ramp_busy   (o_ramp_busy),
        .o_frame_start (o_frame_start),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Pending items, expected outputs, bookkeeping
    servo_cmd_t cmd_q[$];
    servo_out_t expected_out_q[$];
    int         queued_cnt    = 0;
    int         accepted_cnt  = 0;
    int         mismatch_cnt  = 0;
    logic       idle_en       = 1'b1;
    logic       hold_req      = 1'b0;

    // Predictor state
    logic [POS_W-1:0]      servo_pos  [NCH];
    logic [POS_W-1:0]      servo_goal [NCH];
    logic [CFG_DATA_W-1:0] slew_step;
    logic [CFG_DATA_W-1:0] slew_delay;
    logic [4:0]            slot_idx;
    logic [7:0]            slot_tick;
    logic [7:0]            tail_cnt;
    logic                  tail_live;
    logic [3:0]            tail_ch;
    logic [7:0]            slew_wait;
    logic [NCH-1:0]        pin_state;

    task automatic servo_power_up();
        for (int i = 0; i < NCH; i++) begin
            servo_pos[i]  = HOME_POS[(i % 6)*POS_W +: POS_W];
            servo_goal[i] = HOME_POS[(i % 6)*POS_W +: POS_W];
        end
        slew_step  = RAMP_STEP_RST;
        slew_delay = RAMP_DELAY_RST;
        slot_idx   = '0;
        slot_tick  = '0;
        tail_cnt   = '0;
        tail_live  = 1'b0;
        tail_ch    = '0;
        slew_wait  = '0;
        pin_state  = '0;
    endtask

    function automatic logic slew_pending();
        logic busy;
        busy = 1'b0;
        for (int i = 0; i < NCH; i++)
            if (servo_pos[i] != servo_goal[i]) busy = 1'b1;
        return busy;
    endfunction

    // One slew move on every channel, clamped at its goal
    task automatic slew_all();
        int p;
        int t;
        int s;
        s = slew_step;
        for (int i = 0; i < NCH; i++) begin
            p = servo_pos[i];
            t = servo_goal[i];
            if (p < t)
                servo_pos[i] = POS_W'((p + s > t) ? t : p + s);
            else if (p > t)
                servo_pos[i] = POS_W'((p < t + s) ? t : p - s);
        end
    endtask

    // Applies one item to the predictor and queues the output it should produce
    task automatic predict_servo_item(input servo_cmd_t cmd);
        servo_out_t r;
        logic       slot_begin;
        r.fstart = 1'b0;
        if (cmd.req == REQ_TARGET) begin
            if (cmd.ch < NCH) servo_goal[cmd.ch] = cmd.tg;
        end else begin
            slot_begin = (slot_tick == 0);
            // ramp comes first
            if (slot_begin && slew_wait > 0) slew_wait--;
            if (slew_pending()) begin
                if (slew_delay == 0 || slew_wait == 0) begin
                    slew_all();
                    slew_wait = slew_delay;
                end
            end else begin
                slew_wait = '0;
            end
            // slot start: raise this slot's pin, arm the tail of the previous one
            if (slot_begin) begin
                if (slot_idx == 0) r.fstart = 1'b1;
                if (slot_idx < NCH) pin_state[slot_idx] = 1'b1;
                if (slot_idx >= 1 && slot_idx <= NCH) begin
                    // a tail still running past a whole slot is cut here
                    if (tail_live) pin_state[tail_ch] = 1'b0;
                    tail_ch   = 4'(slot_idx - 1);
                    tail_cnt  = servo_pos[tail_ch];
                    tail_live = 1'b1;
                end
            end
            // tail countdown; a zero position drops the pin on the slot edge
            if (tail_live) begin
                if (tail_cnt == 0) begin
                    pin_state[tail_ch] = 1'b0;
                    tail_live = 1'b0;
                end else begin
                    tail_cnt--;
                end
            end
            slot_tick++;
            if (slot_tick >= NTICK) begin
                slot_tick = '0;
                slot_idx++;
                if (slot_idx >= NSLOT) slot_idx = '0;
            end
        end
        r.pins = pin_state;
        r.busy = slew_pending();
        expected_out_q.push_back(r);
    endtask

    // Driver: offers queued items, holds a stalled item unchanged
    servo_cmd_t drv_cmd;
    int         drv_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            drv_gap = 0;
        end else if (!(i_valid && o_stall)) begin
            if (drv_gap > 0) begin
                drv_gap--;
                i_valid <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                drv_gap = $urandom_range(0, 3);
                i_valid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                drv_cmd = cmd_q.pop_front();
                i_valid    <= 1'b1;
                i_req_type <= drv_cmd.req;
                i_channel  <= drv_cmd.ch;
                i_target   <= drv_cmd.tg;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks outputs, then folds in config writes and accepted items
    servo_out_t mon_exp;
    int         hold_left  = 0;
    int         stall_gap  = 0;
    logic       hold_done  = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            servo_power_up();
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_out_q.size() == 0) begin
                    $display("%0t: unexpected output pins %h busy %b frame %b", $time,
                             o_servo_pins, o_ramp_busy, o_frame_start);
                    mismatch_cnt++;
                end else begin
                    mon_exp = expected_out_q.pop_front();
                    if (o_servo_pins !== mon_exp.pins) begin
                        $display("%0t: servo_pins expected %h actual %h", $time,
                                 mon_exp.pins, o_servo_pins);
                        mismatch_cnt++;
                    end
                    if (o_ramp_busy !== mon_exp.busy) begin
                        $display("%0t: ramp_busy expected %b actual %b", $time,
                                 mon_exp.busy, o_ramp_busy);
                        mismatch_cnt++;
                    end
                    if (o_frame_start !== mon_exp.fstart) begin
                        $display("%0t: frame_start expected %b actual %b", $time,
                                 mon_exp.fstart, o_frame_start);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_RAMP_STEP:  slew_step  = i_cfg_wdata;
                    REG_RAMP_DELAY: slew_delay = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                accepted_cnt++;
                predict_servo_item('{i_req_type, i_channel, i_target});
            end
            // receiver back-pressure: one long hold on request, else short bursts
            if (hold_req && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_gap > 0) begin
                stall_gap--;
                i_stall <= 1'b1;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_gap = $urandom_range(0, 3);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    int quiet_cnt = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cnt = 0;
            else
                quiet_cnt++;
            if (quiet_cnt >= QUIET_MAX) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cnt);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic add_item(input logic req, input logic [CH_FIELD_W-1:0] ch,
                            input logic [POS_W-1:0] tg);
        cmd_q.push_back('{req, ch, tg});
        queued_cnt++;
    endtask

    // goals lean on the corners: zero tail, full range, tails past a slot
    function automatic logic [POS_W-1:0] pick_goal();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return 8'd255;
            3:       return POS_W'($urandom_range(NTICK - 5, 255));
            default: return POS_W'($urandom);
        endcase
    endfunction

    // Mostly ticks, with goal writes mixed in, some to unused channels.
    // Ticks carry random don't-care payload.
    task automatic add_random(input int n);
        repeat (n) begin
            if ($urandom_range(0, 99) < 6)
                add_item(REQ_TARGET, CH_FIELD_W'($urandom_range(0, 15)), pick_goal());
            else
                add_item(REQ_TICK, CH_FIELD_W'($urandom), POS_W'($urandom));
        end
    endtask

    // Waits for every item and output to pass, then lets the pipe drain
    task automatic drain();
        while (accepted_cnt != queued_cnt || expected_out_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] step,
                             input logic [CFG_DATA_W-1:0] dly, input int n);
        write_reg(REG_RAMP_STEP, step);
        write_reg(REG_RAMP_DELAY, dly);
        add_random(n);
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: frame start, goal corners, ignored channels, first ramp move
        add_item(REQ_TICK, 4'd0, 8'd0);
        add_item(REQ_TARGET, 4'd0, 8'd0);
        add_item(REQ_TARGET, 4'd1, 8'd255);
        add_item(REQ_TARGET, 4'd2, 8'd125);
        add_item(REQ_TARGET, 4'd3, 8'd250);
        add_item(REQ_TARGET, 4'd11, 8'd0);
        add_item(REQ_TARGET, 4'd12, 8'd77);
        add_item(REQ_TARGET, 4'd15, 8'd255);
        repeat (4) add_item(REQ_TICK, 4'd15, 8'd255);
        add_item(REQ_TARGET, 4'd4, 8'd25);
        add_item(REQ_TICK, 4'd0, 8'd0);
        add_random(300);
        drain();

        // long back-pressure stretch while the sender keeps offering
        hold_req = 1'b1;
        run_phase(8'd255, 8'd0, 400);
        run_phase(8'd0, 8'd0, 100);     // zero step: ramp stays busy
        run_phase(8'd3, 8'd1, 400);
        run_phase(8'd1, 8'd255, 200);
        idle_en = 1'b0;                 // last stretch runs at full rate
        run_phase(8'd128, 8'd0, 400);

        if (mismatch_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
